[rtl/core/grff_pkg.sv]
// Shared types and constants of the grid region flood fill.
`timescale 1ns / 1ps
package grff_pkg;

   localparam int COORD_BITS_DEF  = 8;
   localparam int STACK_DEPTH_DEF = 8192;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;
   localparam int COUNT_BITS     = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_TOP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISC_CX     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISC_CY     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISC_RSQ    = 3'd6;

   localparam logic signed [7:0] RESET_RECT_LEFT   = -8'sd50;
   localparam logic signed [7:0] RESET_RECT_RIGHT  = 8'sd50;
   localparam logic signed [7:0] RESET_RECT_BOTTOM = -8'sd30;
   localparam logic signed [7:0] RESET_RECT_TOP    = 8'sd30;
   localparam logic signed [7:0] RESET_DISC_CX     = -8'sd5;
   localparam logic signed [7:0] RESET_DISC_CY     = 8'sd0;
   localparam logic [16:0]       RESET_DISC_RSQ    = 17'd400;

   localparam logic OP_FILL  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_DISC = 2'd1;
   localparam logic [1:0] HIT_RECT = 2'd2;

   typedef struct packed {
      logic signed [7:0] rect_left;
      logic signed [7:0] rect_right;
      logic signed [7:0] rect_bottom;
      logic signed [7:0] rect_top;
      logic signed [7:0] disc_center_x;
      logic signed [7:0] disc_center_y;
      logic [16:0]       disc_radius_sq;
   } cfg_type;

   typedef struct packed {
      logic on_grid;
      logic in_disc;
      logic in_rect;
   } region_type;

endpackage

[rtl/core/grff_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module grff_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/grff_region.sv]
// Region test of one probe cell: grid bounds, rectangle and disc, squares registered.
`timescale 1ns / 1ps
module grff_region #(
   parameter int COORD_BITS = grff_pkg::COORD_BITS_DEF,
   localparam int CW = ((COORD_BITS > 8) ? COORD_BITS : 8) + 2
) (
   input  logic                  clock,
   input  grff_pkg::cfg_type     cfg,
   input  logic signed [CW-1:0]  probe_x,
   input  logic signed [CW-1:0]  probe_y,
   output grff_pkg::region_type  region
);
   import grff_pkg::*;

   localparam int DW   = CW + 1;
   localparam int SQW  = 2 * DW;
   localparam int HALF = 1 << (COORD_BITS - 1);
   localparam logic signed [CW-1:0] GRID_MIN = CW'(-HALF);
   localparam logic signed [CW-1:0] GRID_MAX = CW'(HALF - 1);

   logic signed [DW-1:0]  dx, dy;
   logic signed [SQW-1:0] dx2, dy2;
   logic                  grid_in, rect_in;
   logic [SQW-1:0]        dx2_ff, dy2_ff;
   logic                  grid_ff, rect_ff;
   logic [SQW:0]          dist_sq;

   assign dx  = DW'(probe_x) - DW'(cfg.disc_center_x);
   assign dy  = DW'(probe_y) - DW'(cfg.disc_center_y);
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;

   assign grid_in = (probe_x >= GRID_MIN) && (probe_x <= GRID_MAX) &&
                    (probe_y >= GRID_MIN) && (probe_y <= GRID_MAX);
   assign rect_in = (probe_x >= CW'(cfg.rect_left))   && (probe_x <= CW'(cfg.rect_right)) &&
                    (probe_y >= CW'(cfg.rect_bottom)) && (probe_y <= CW'(cfg.rect_top));

   always_ff @(posedge clock) begin
      dx2_ff  <= $unsigned(dx2);
      dy2_ff  <= $unsigned(dy2);
      grid_ff <= grid_in;
      rect_ff <= grid_in && rect_in;
   end

   assign dist_sq        = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign region.on_grid = grid_ff;
   assign region.in_rect = rect_ff;
   assign region.in_disc = grid_ff && (dist_sq <= (SQW+1)'(cfg.disc_radius_sq));

endmodule

[rtl/core/grid_region_flood_fill.sv]
// After reset a clearing pass over all 2^(2*COORD_BITS) cells (65536 by default) zeroes
// both bitmaps; no command is taken until it ends. Configuration writes are always taken.
// A query, or a fill that marks nothing, goes from transfer through the seed read and the
// seed check to the result. A fill then pops each cell from the stack and reads and checks
// its four neighbors one at a time, as the single bitmap read port and registered read data require.
// A new command is taken once the result is loaded, even while it still waits.
`timescale 1ns / 1ps
module grid_region_flood_fill #(
   parameter int COORD_BITS  = grff_pkg::COORD_BITS_DEF,
   parameter int STACK_DEPTH = grff_pkg::STACK_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [7:0]                    req_cell_x,
   input  logic signed [7:0]                    req_cell_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_region_hit,
   output logic [grff_pkg::COUNT_BITS-1:0]      rsp_cells_added,
   output logic                                 rsp_disc_mark,
   output logic                                 rsp_rect_mark,
   output logic                                 rsp_stack_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [grff_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [grff_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import grff_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int CW     = ((CB > 8) ? CB : 8) + 2;
   localparam int CELLW  = 2 * CB;
   localparam int CELLS  = 1 << CELLW;
   localparam int SAW    = $clog2(STACK_DEPTH);
   localparam int SPW    = $clog2(STACK_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_SEED     = 9'b000000100,
      ST_SEED_CHK = 9'b000001000,
      ST_POP      = 9'b000010000,
      ST_POP_WAIT = 9'b000100000,
      ST_NBR      = 9'b001000000,
      ST_NBR_CHK  = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   cfg_type cfg_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rect_left      <= RESET_RECT_LEFT;
         cfg_ff.rect_right     <= RESET_RECT_RIGHT;
         cfg_ff.rect_bottom    <= RESET_RECT_BOTTOM;
         cfg_ff.rect_top       <= RESET_RECT_TOP;
         cfg_ff.disc_center_x  <= RESET_DISC_CX;
         cfg_ff.disc_center_y  <= RESET_DISC_CY;
         cfg_ff.disc_radius_sq <= RESET_DISC_RSQ;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RECT_LEFT:   cfg_ff.rect_left      <= csr_data[7:0];
            CSR_RECT_RIGHT:  cfg_ff.rect_right     <= csr_data[7:0];
            CSR_RECT_BOTTOM: cfg_ff.rect_bottom    <= csr_data[7:0];
            CSR_RECT_TOP:    cfg_ff.rect_top       <= csr_data[7:0];
            CSR_DISC_CX:     cfg_ff.disc_center_x  <= csr_data[7:0];
            CSR_DISC_CY:     cfg_ff.disc_center_y  <= csr_data[7:0];
            CSR_DISC_RSQ:    cfg_ff.disc_radius_sq <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Working registers.
   logic                    op_ff;
   logic signed [CW-1:0]    seed_x_ff, seed_y_ff;
   logic [CELLW-1:0]        cur_ff, cur_in;
   logic [CELLW-1:0]        probe_cell_ff;
   logic [1:0]              dir_ff, dir_in;
   logic [SPW-1:0]          sp_ff, sp_in;
   logic [CELLW-1:0]        clr_ff, clr_in;
   logic                    disc_sel_ff, disc_sel_in;
   logic [1:0]              hit_ff, hit_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic                    dm_ff, dm_in, rm_ff, rm_in;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_hit_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_dm_ff, rsp_rm_ff, rsp_ovf_ff;

   // Probe coordinates: the seed, or the current cell moved one step.
   logic signed [CW-1:0] cur_x, cur_y, probe_x, probe_y;
   logic [CELLW-1:0]     probe_cell;
   region_type           region;

   assign cur_x = {{(CW-CB+1){~cur_ff[CELLW-1]}}, cur_ff[CELLW-2:CB]};
   assign cur_y = {{(CW-CB+1){~cur_ff[CB-1]}}, cur_ff[CB-2:0]};

   always_comb begin
      probe_x = cur_x;
      probe_y = cur_y;
      if (state_ff == ST_SEED) begin
         probe_x = seed_x_ff;
         probe_y = seed_y_ff;
      end else begin
         unique case (dir_ff)
            2'd0: probe_x = cur_x - CW'(1);
            2'd1: probe_y = cur_y - CW'(1);
            2'd2: probe_x = cur_x + CW'(1);
            2'd3: probe_y = cur_y + CW'(1);
            default: ;
         endcase
      end
   end

   assign probe_cell = {~probe_x[CB-1], probe_x[CB-2:0], ~probe_y[CB-1], probe_y[CB-2:0]};

   grff_region #(
      .COORD_BITS(COORD_BITS)
   ) u_region (
      .clock   (clock),
      .cfg     (cfg_ff),
      .probe_x (probe_x),
      .probe_y (probe_y),
      .region  (region)
   );

   // Bitmap memory: bit 0 is the disc bitmap, bit 1 the rectangle bitmap.
   logic              map_wr_en, map_rd_en;
   logic [CELLW-1:0]  map_wr_addr;
   logic [1:0]        map_wr_data, map_rd_data;

   grff_ram #(
      .WIDTH(2),
      .DEPTH(CELLS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (probe_cell),
      .rd_data (map_rd_data)
   );

   logic              stk_wr_en, stk_rd_en;
   logic [SAW-1:0]    stk_wr_addr, stk_rd_addr;
   logic [CELLW-1:0]  stk_wr_data, stk_rd_data;

   grff_ram #(
      .WIDTH(CELLW),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   logic       probe_in_region, probe_marked;
   logic [1:0] mark_bit;

   assign probe_in_region = disc_sel_ff ? region.in_disc : region.in_rect;
   assign probe_marked    = disc_sel_ff ? map_rd_data[0] : map_rd_data[1];
   assign mark_bit        = disc_sel_ff ? 2'b01 : 2'b10;

   assign req_ready   = (state_ff == ST_IDLE);
   assign stk_rd_addr = SAW'(sp_ff - SPW'(1));
   assign stk_wr_addr = sp_ff[SAW-1:0];
   assign stk_wr_data = probe_cell_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      dir_in      = dir_ff;
      sp_in       = sp_ff;
      clr_in      = clr_ff;
      disc_sel_in = disc_sel_ff;
      hit_in      = hit_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      dm_in       = dm_ff;
      rm_in       = rm_ff;
      map_wr_en   = 1'b0;
      map_wr_addr = probe_cell_ff;
      map_wr_data = map_rd_data | mark_bit;
      map_rd_en   = 1'b0;
      stk_wr_en   = 1'b0;
      stk_rd_en   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            map_wr_data = 2'b00;
            clr_in      = clr_ff + CELLW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               hit_in   = HIT_NONE;
               count_in = '0;
               ovf_in   = 1'b0;
               dm_in    = 1'b0;
               rm_in    = 1'b0;
               sp_in    = '0;
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            map_rd_en = 1'b1;
            state_in  = ST_SEED_CHK;
         end
         ST_SEED_CHK: begin
            state_in = ST_DONE;
            if (op_ff == OP_QUERY) begin
               dm_in = region.on_grid && map_rd_data[0];
               rm_in = region.on_grid && map_rd_data[1];
            end else if (region.in_disc || region.in_rect) begin
               disc_sel_in = region.in_disc;
               hit_in      = region.in_disc ? HIT_DISC : HIT_RECT;
               // The seed is marked and pushed unless it is already marked.
               if (!(region.in_disc ? map_rd_data[0] : map_rd_data[1])) begin
                  map_wr_en   = 1'b1;
                  map_wr_data = map_rd_data | (region.in_disc ? 2'b01 : 2'b10);
                  stk_wr_en   = 1'b1;
                  sp_in       = SPW'(1);
                  count_in    = COUNT_BITS'(1);
                  state_in    = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               stk_rd_en = 1'b1;
               sp_in     = sp_ff - SPW'(1);
               state_in  = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cur_in   = stk_rd_data;
            dir_in   = 2'd0;
            state_in = ST_NBR;
         end
         ST_NBR: begin
            map_rd_en = 1'b1;
            state_in  = ST_NBR_CHK;
         end
         ST_NBR_CHK: begin
            dir_in   = dir_ff + 2'd1;
            state_in = (dir_ff == 2'd3) ? ST_POP : ST_NBR;
            if (probe_in_region && !probe_marked) begin
               if (sp_ff == SPW'(STACK_DEPTH)) begin
                  ovf_in   = 1'b1;
                  sp_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  map_wr_en = 1'b1;
                  stk_wr_en = 1'b1;
                  sp_in     = sp_ff + SPW'(1);
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_BITS'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      dir_ff      <= dir_in;
      disc_sel_ff <= disc_sel_in;
      hit_ff      <= hit_in;
      count_ff    <= count_in;
      ovf_ff      <= ovf_in;
      dm_ff       <= dm_in;
      rm_ff       <= rm_in;
      if (state_ff == ST_SEED || state_ff == ST_NBR) begin
         probe_cell_ff <= probe_cell;
      end
      if (req_valid && req_ready) begin
         op_ff     <= req_operation;
         seed_x_ff <= CW'(req_cell_x);
         seed_y_ff <= CW'(req_cell_y);
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_hit_ff   <= hit_ff;
         rsp_count_ff <= count_ff;
         rsp_dm_ff    <= dm_ff;
         rsp_rm_ff    <= rm_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_region_hit     = rsp_hit_ff;
   assign rsp_cells_added    = rsp_count_ff;
   assign rsp_disc_mark      = rsp_dm_ff;
   assign rsp_rect_mark      = rsp_rm_ff;
   assign rsp_stack_overflow = rsp_ovf_ff;

endmodule
